[sv/sip_pkg.sv]
// Shared widths and beat layouts for the segment intersection core.
// No dependencies; imported by the core and by its port checker.
package sip_pkg;

  // Coordinate width of every input field (two's complement), 8..32.
  localparam int COORD_W   = 24;

  // Start-point difference, one extra bit.
  localparam int DELTA_W   = COORD_W + 1;
  // Direction-by-direction product.
  localparam int PROD_W    = 2 * COORD_W;
  // Difference-by-direction product.
  localparam int DPROD_W   = DELTA_W + COORD_W;
  // Denominator cross product, signed.
  localparam int DEN_W     = PROD_W + 1;
  // Numerator cross products, signed.
  localparam int NUM_W     = DPROD_W + 1;
  // Magnitude of the denominator (and of an in-range numerator).
  localparam int MAG_W     = 2 * COORD_W;

  // Q0.16 fraction, plus one bit for the full-length case.
  localparam int FRAC_BITS = 16;
  localparam int T_W       = FRAC_BITS + 1;

  // Stream beat widths.
  localparam int S_TDATA_W = ((8 * COORD_W + 7) / 8) * 8;
  localparam int M_TDATA_W = ((T_W + 7) / 8) * 8;
  localparam int M_TUSER_W = 1;

  // Field slots in the input beat, lowest first.
  localparam int F_AX  = 0;
  localparam int F_AY  = 1;
  localparam int F_ADX = 2;
  localparam int F_ADY = 3;
  localparam int F_BX  = 4;
  localparam int F_BY  = 5;
  localparam int F_BDX = 6;
  localparam int F_BDY = 7;

  // One restoring division stage.
  typedef struct packed {
    logic                 hit;
    logic                 full;
    logic [MAG_W-1:0]     den;
    logic [MAG_W-1:0]     rem;
    logic [FRAC_BITS-1:0] quo;
  } div_stage_t;

endpackage

[sv/segment_intersection_param_core.sv]
// Top level of the 2-D segment intersection core: cross products,
// range tests and a 16-stage restoring divider. Depends on sip_pkg.
//
//  channel  | dir | tdata (lsb up)                                  | tuser
//  ---------+-----+-------------------------------------------------+------
//  s_axis   | in  | a_x a_y a_dx a_dy b_x b_y b_dx b_dy (COORD_W ea) | -
//  m_axis   | out | t_frac[16:0], zero pad to byte                  | hit
//
//  One beat in per cycle while the output is not stalled; the path is four stages of
//  multiply, subtract and range test, one magnitude stage, sixteen
//  restoring divider stages (one quotient bit each), and the output reg.
//  Reset clears the valid bits only; no clearing pass.
//  The whole pipeline advances when the output register is empty or
//  taken, so a stall holds every stage in place.
module segment_intersection_param_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // a_x, a_y, a_dx, a_dy, b_x, b_y, b_dx, b_dy
  input  logic [sip_pkg::S_TDATA_W-1:0] s_tdata_i,
  input  logic                          s_tvalid_i,
  output logic                          s_tready_o,
  // t_frac, then zero padding
  output logic [sip_pkg::M_TDATA_W-1:0] m_tdata_o,
  // hit
  output logic [sip_pkg::M_TUSER_W-1:0] m_tuser_o,
  output logic                          m_tvalid_o,
  input  logic                          m_tready_i
);
  import sip_pkg::*;

  // Pipeline advance
  logic ce;
  logic m_vld_q;
  assign ce         = !m_vld_q || m_tready_i;
  assign s_tready_o = ce;

  // Input field unpack
  logic signed [COORD_W-1:0] ax, ay, adx, ady, bx, by, bdx, bdy;
  assign ax  = s_tdata_i[F_AX  * COORD_W +: COORD_W];
  assign ay  = s_tdata_i[F_AY  * COORD_W +: COORD_W];
  assign adx = s_tdata_i[F_ADX * COORD_W +: COORD_W];
  assign ady = s_tdata_i[F_ADY * COORD_W +: COORD_W];
  assign bx  = s_tdata_i[F_BX  * COORD_W +: COORD_W];
  assign by  = s_tdata_i[F_BY  * COORD_W +: COORD_W];
  assign bdx = s_tdata_i[F_BDX * COORD_W +: COORD_W];
  assign bdy = s_tdata_i[F_BDY * COORD_W +: COORD_W];

  // Stage 1: start difference and denominator products
  logic                      s1_vld_q;
  logic signed [DELTA_W-1:0] s1_dx_q, s1_dy_q;
  logic signed [PROD_W-1:0]  s1_p0_q, s1_p1_q;
  logic signed [COORD_W-1:0] s1_adx_q, s1_ady_q, s1_bdx_q, s1_bdy_q;
  logic signed [DELTA_W-1:0] s1_dx_d, s1_dy_d;
  logic signed [PROD_W-1:0]  s1_p0_d, s1_p1_d;

  always_comb begin
    s1_dx_d = {bx[COORD_W-1], bx} - {ax[COORD_W-1], ax};
    s1_dy_d = {by[COORD_W-1], by} - {ay[COORD_W-1], ay};
    s1_p0_d = PROD_W'(adx) * PROD_W'(bdy);
    s1_p1_d = PROD_W'(ady) * PROD_W'(bdx);
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      s1_dx_q  <= s1_dx_d;
      s1_dy_q  <= s1_dy_d;
      s1_p0_q  <= s1_p0_d;
      s1_p1_q  <= s1_p1_d;
      s1_adx_q <= adx;
      s1_ady_q <= ady;
      s1_bdx_q <= bdx;
      s1_bdy_q <= bdy;
    end
  end

  // Stage 2: denominator, numerator products
  logic                      s2_vld_q;
  logic signed [DEN_W-1:0]   s2_den_q;
  logic signed [DPROD_W-1:0] s2_m0_q, s2_m1_q, s2_m2_q, s2_m3_q;
  logic signed [DEN_W-1:0]   s2_den_d;
  logic signed [DPROD_W-1:0] s2_m0_d, s2_m1_d, s2_m2_d, s2_m3_d;

  always_comb begin
    s2_den_d = {s1_p0_q[PROD_W-1], s1_p0_q} - {s1_p1_q[PROD_W-1], s1_p1_q};
    s2_m0_d  = DPROD_W'(s1_dx_q) * DPROD_W'(s1_bdy_q);
    s2_m1_d  = DPROD_W'(s1_dy_q) * DPROD_W'(s1_bdx_q);
    s2_m2_d  = DPROD_W'(s1_dx_q) * DPROD_W'(s1_ady_q);
    s2_m3_d  = DPROD_W'(s1_dy_q) * DPROD_W'(s1_adx_q);
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      s2_den_q <= s2_den_d;
      s2_m0_q  <= s2_m0_d;
      s2_m1_q  <= s2_m1_d;
      s2_m2_q  <= s2_m2_d;
      s2_m3_q  <= s2_m3_d;
    end
  end

  // Stage 3: numerators ua = cross(d, b_dir), ub = cross(d, a_dir)
  logic                    s3_vld_q;
  logic signed [DEN_W-1:0] s3_den_q;
  logic signed [NUM_W-1:0] s3_ua_q, s3_ub_q;
  logic signed [NUM_W-1:0] s3_ua_d, s3_ub_d;

  always_comb begin
    s3_ua_d = {s2_m0_q[DPROD_W-1], s2_m0_q} - {s2_m1_q[DPROD_W-1], s2_m1_q};
    s3_ub_d = {s2_m2_q[DPROD_W-1], s2_m2_q} - {s2_m3_q[DPROD_W-1], s2_m3_q};
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      s3_den_q <= s2_den_q;
      s3_ua_q  <= s3_ua_d;
      s3_ub_q  <= s3_ub_d;
    end
  end

  // Stage 4: range test, zero numerator counts as inside
  logic                    s4_vld_q;
  logic                    s4_hit_q;
  logic signed [DEN_W-1:0] s4_den_q;
  logic signed [NUM_W-1:0] s4_ua_q;
  logic signed [NUM_W-1:0] den_x;
  logic                    den_neg, den_zero, ua_in, ub_in, s4_hit_d;

  always_comb begin
    den_x    = {s3_den_q[DEN_W-1], s3_den_q};
    den_neg  = s3_den_q[DEN_W-1];
    den_zero = (s3_den_q == '0);
    if (den_neg) begin
      ua_in = !(s3_ua_q > 0) && (s3_ua_q >= den_x);
      ub_in = !(s3_ub_q > 0) && (s3_ub_q >= den_x);
    end else begin
      ua_in = !s3_ua_q[NUM_W-1] && (s3_ua_q <= den_x);
      ub_in = !s3_ub_q[NUM_W-1] && (s3_ub_q <= den_x);
    end
    s4_hit_d = !den_zero && ua_in && ub_in;
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      s4_hit_q <= s4_hit_d;
      s4_den_q <= s3_den_q;
      s4_ua_q  <= s3_ua_q;
    end
  end

  // Stage 5: magnitudes and full-length flag feed the divider
  div_stage_t              div_q [FRAC_BITS+1];
  logic [FRAC_BITS:0]      div_vld_q;
  div_stage_t              div0_d;
  logic signed [DEN_W-1:0] den_abs;
  logic signed [NUM_W-1:0] ua_abs;

  always_comb begin
    den_abs     = s4_den_q[DEN_W-1] ? -s4_den_q : s4_den_q;
    ua_abs      = s4_ua_q[NUM_W-1] ? -s4_ua_q : s4_ua_q;
    div0_d.hit  = s4_hit_q;
    div0_d.full = (s4_ua_q == {s4_den_q[DEN_W-1], s4_den_q});
    div0_d.den  = den_abs[MAG_W-1:0];
    div0_d.rem  = ua_abs[MAG_W-1:0];
    div0_d.quo  = '0;
  end

  // Divider stages: one restoring step each
  div_stage_t     div_d [1:FRAC_BITS];
  logic [MAG_W:0] trial;

  always_comb begin
    trial = '0;
    for (int k = 1; k <= FRAC_BITS; k++) begin
      trial    = {div_q[k-1].rem, 1'b0} - {1'b0, div_q[k-1].den};
      div_d[k] = div_q[k-1];
      if (!trial[MAG_W]) begin
        div_d[k].rem = trial[MAG_W-1:0];
        div_d[k].quo = {div_q[k-1].quo[FRAC_BITS-2:0], 1'b1};
      end else begin
        div_d[k].rem = {div_q[k-1].rem[MAG_W-2:0], 1'b0};
        div_d[k].quo = {div_q[k-1].quo[FRAC_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      div_q[0] <= div0_d;
      for (int k = 1; k <= FRAC_BITS; k++) begin
        div_q[k] <= div_d[k];
      end
    end
  end

  // Output register
  logic                 m_hit_q;
  logic [T_W-1:0]       m_frac_q;
  logic [T_W-1:0]       m_frac_d;
  div_stage_t           last;

  always_comb begin
    last = div_q[FRAC_BITS];
    if (!last.hit) begin
      m_frac_d = '0;
    end else if (last.full) begin
      m_frac_d = {1'b1, {FRAC_BITS{1'b0}}};
    end else begin
      m_frac_d = {1'b0, last.quo};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      m_hit_q  <= last.hit;
      m_frac_q <= m_frac_d;
    end
  end

  // Valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      div_vld_q <= '0;
      m_vld_q   <= 1'b0;
    end else if (ce) begin
      s1_vld_q  <= s_tvalid_i;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= s2_vld_q;
      s4_vld_q  <= s3_vld_q;
      div_vld_q <= {div_vld_q[FRAC_BITS-1:0], s4_vld_q};
      m_vld_q   <= div_vld_q[FRAC_BITS];
    end
  end

  assign m_tvalid_o = m_vld_q;
  assign m_tuser_o  = M_TUSER_W'(m_hit_q);
  assign m_tdata_o  = M_TDATA_W'(m_frac_q);

endmodule

[sv/sip_checker.sv]
// Port-level checker for segment_intersection_param_core, with its bind.
// Depends on sip_pkg for the beat widths.
module sip_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic [sip_pkg::S_TDATA_W-1:0] s_tdata_i,
  input logic                          s_tvalid_i,
  input logic                          s_tready_o,
  input logic [sip_pkg::M_TDATA_W-1:0] m_tdata_o,
  input logic [sip_pkg::M_TUSER_W-1:0] m_tuser_o,
  input logic                          m_tvalid_o,
  input logic                          m_tready_i
);
  import sip_pkg::*;

  // A stalled result beat holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> m_tvalid_o && $stable(m_tdata_o) && $stable(m_tuser_o))
    else $error("result beat changed while stalled");

  // Input side is ready exactly when the output register can move
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tready_o == (!m_tvalid_o || m_tready_i))
    else $error("input ready does not follow output register");

  // A miss carries a zero fraction
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tuser_o[0] |-> m_tdata_o == '0)
    else $error("miss with nonzero fraction");

  // Fraction never exceeds one, and one only on a hit
  a_frac_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tdata_o[FRAC_BITS] |-> m_tuser_o[0] && m_tdata_o[FRAC_BITS-1:0] == '0)
    else $error("fraction above one");

endmodule

bind segment_intersection_param_core sip_checker u_sip_checker (.*);

[test/sip_crossing_checker.sv]
`timescale 1ns / 1ps
// Stream checker for the segment intersection core: predicts hit and t_frac
// for every input beat and compares them with the output beats in order.
// Depends on sip_pkg.
module sip_crossing_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [sip_pkg::S_TDATA_W-1:0] s_tdata_i,
  input  logic                          s_tvalid_i,
  input  logic                          s_tready_i,
  input  logic [sip_pkg::M_TDATA_W-1:0] m_tdata_i,
  input  logic [sip_pkg::M_TUSER_W-1:0] m_tuser_i,
  input  logic                          m_tvalid_i,
  input  logic                          m_tready_i,
  output int                            errors_o,
  output logic                          drained_o
);
  import sip_pkg::*;

  // Wide enough for every cross product without overflow.
  localparam int WW = 2 * COORD_W + 4;
  typedef logic signed [WW-1:0] wide_t;
  typedef logic [WW+16:0]       quot_t;

  typedef struct packed {
    logic           hit;
    logic [T_W-1:0] t_frac;
  } crossing_t;

  crossing_t expected_crossings_q[$];
  crossing_t want;
  int        mismatches = 0;
  logic      drained_q  = 1'b1;

  assign errors_o  = mismatches;
  assign drained_o = drained_q;

  // Sign-extend one coordinate slot of the input beat.
  function automatic wide_t coord_at(input logic [S_TDATA_W-1:0] d, input int slot);
    logic signed [COORD_W-1:0] f;
    f = d[slot*COORD_W +: COORD_W];
    return wide_t'(f);
  endfunction

  function automatic wide_t mag(input wide_t v);
    return (v < 0) ? -v : v;
  endfunction

  // Ratio num/den within 0..1, a zero numerator counts as inside.
  function automatic logic in_unit_range(input wide_t num, input wide_t den);
    if (num != 0 && ((num < 0) != (den < 0)))
      return 1'b0;
    return mag(num) <= mag(den);
  endfunction

  function automatic crossing_t predict_crossing(input logic [S_TDATA_W-1:0] d);
    wide_t     ax, ay, adx, ady, bx, by, bdx, bdy;
    wide_t     den, dx, dy, ua, ub;
    quot_t     num_m, den_m, q;
    crossing_t r;
    ax  = coord_at(d, F_AX);
    ay  = coord_at(d, F_AY);
    adx = coord_at(d, F_ADX);
    ady = coord_at(d, F_ADY);
    bx  = coord_at(d, F_BX);
    by  = coord_at(d, F_BY);
    bdx = coord_at(d, F_BDX);
    bdy = coord_at(d, F_BDY);
    r = '0;
    den = adx * bdy - ady * bdx;
    if (den == 0)
      return r;
    dx = bx - ax;
    dy = by - ay;
    ua = dx * bdy - dy * bdx;
    ub = dx * ady - dy * adx;
    if (!in_unit_range(ua, den) || !in_unit_range(ub, den))
      return r;
    num_m = quot_t'(mag(ua));
    den_m = quot_t'(mag(den));
    if (num_m == den_m)
      q = quot_t'(1) << FRAC_BITS;
    else
      q = (num_m << FRAC_BITS) / den_m;
    r.hit    = 1'b1;
    r.t_frac = q[T_W-1:0];
    return r;
  endfunction

  // Results are retired before new inputs are queued; latency keeps them apart.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_tvalid_i && m_tready_i) begin
        if (expected_crossings_q.size() == 0) begin
          $error("result beat with nothing pending: hit %0d t_frac %0d",
                 m_tuser_i[0], m_tdata_i[T_W-1:0]);
          mismatches++;
        end else begin
          want = expected_crossings_q.pop_front();
          if (m_tuser_i[0] !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, m_tuser_i[0]);
            mismatches++;
          end
          if (m_tdata_i[T_W-1:0] !== want.t_frac) begin
            $error("t_frac: expected %0d, got %0d", want.t_frac, m_tdata_i[T_W-1:0]);
            mismatches++;
          end
          if (m_tdata_i[M_TDATA_W-1:T_W] !== '0) begin
            $error("tdata pad: expected 0, got %0h", m_tdata_i[M_TDATA_W-1:T_W]);
            mismatches++;
          end
        end
      end
      if (s_tvalid_i && s_tready_i)
        expected_crossings_q.push_back(predict_crossing(s_tdata_i));
      drained_q <= (expected_crossings_q.size() == 0);
    end
  end

endmodule

[test/tb_segment_intersection_param_core.sv]
`timescale 1ns / 1ps
// Testbench top for segment_intersection_param_core: directed and random
// segment pairs with random stalls on both sides. Depends on sip_pkg and
// sip_crossing_checker.
module tb_segment_intersection_param_core;
  import sip_pkg::*;

  localparam int CMIN        = -(1 << (COORD_W - 1));
  localparam int CMAX        = (1 << (COORD_W - 1)) - 1;
  localparam int RANDOM_BEATS = 1130;
  localparam int QUIET_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 40;

  logic                 clk     = 1'b0;
  logic                 rst_n   = 1'b0;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [M_TUSER_W-1:0] m_tuser;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic                 calm     = 1'b0;
  logic                 drained;
  int                   errors;
  int                   quiet_cycles = 0;

  segment_intersection_param_core u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .s_tdata_i  (s_tdata),
    .s_tvalid_i (s_tvalid),
    .s_tready_o (s_tready),
    .m_tdata_o  (m_tdata),
    .m_tuser_o  (m_tuser),
    .m_tvalid_o (m_tvalid),
    .m_tready_i (m_tready)
  );

  sip_crossing_checker u_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .s_tdata_i  (s_tdata),
    .s_tvalid_i (s_tvalid),
    .s_tready_i (s_tready),
    .m_tdata_i  (m_tdata),
    .m_tuser_i  (m_tuser),
    .m_tvalid_i (m_tvalid),
    .m_tready_i (m_tready),
    .errors_o   (errors),
    .drained_o  (drained)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Receiver: random backpressure, none during the calm stretch.
  always @(posedge clk) begin
    if (rst_n)
      m_tready <= calm || ($urandom_range(0, 99) >= 32);
  end

  // Watchdog on cycles without any beat moving.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Present one beat after optional gaps, return right after it is taken.
  task automatic put_beat(input logic [S_TDATA_W-1:0] d);
    logic taken;
    while (!calm && $urandom_range(0, 99) < 32) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    do begin
      @(negedge clk);
      taken = s_tready;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic put_coords(input int ax, input int ay, input int adx, input int ady,
                            input int bx, input int by, input int bdx, input int bdy);
    logic [S_TDATA_W-1:0] d;
    d = '0;
    d[F_AX*COORD_W  +: COORD_W] = ax[COORD_W-1:0];
    d[F_AY*COORD_W  +: COORD_W] = ay[COORD_W-1:0];
    d[F_ADX*COORD_W +: COORD_W] = adx[COORD_W-1:0];
    d[F_ADY*COORD_W +: COORD_W] = ady[COORD_W-1:0];
    d[F_BX*COORD_W  +: COORD_W] = bx[COORD_W-1:0];
    d[F_BY*COORD_W  +: COORD_W] = by[COORD_W-1:0];
    d[F_BDX*COORD_W +: COORD_W] = bdx[COORD_W-1:0];
    d[F_BDY*COORD_W +: COORD_W] = bdy[COORD_W-1:0];
    put_beat(d);
  endtask

  // Hold the sender until every result is back.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (!drained);
    @(posedge clk);
  endtask

  function automatic int span(input int lim);
    return int'($urandom_range(0, 2 * lim)) - lim;
  endfunction

  // Any value across the whole field, extremes favored.
  function automatic logic [S_TDATA_W-1:0] raw_pair();
    logic [S_TDATA_W-1:0] d;
    int                   pick;
    d = '0;
    for (int f = 0; f < 8; f++) begin
      pick = $urandom_range(0, 99);
      if (pick < 10)
        d[f*COORD_W +: COORD_W] = CMIN[COORD_W-1:0];
      else if (pick < 20)
        d[f*COORD_W +: COORD_W] = CMAX[COORD_W-1:0];
      else if (pick < 25)
        d[f*COORD_W +: COORD_W] = '0;
      else
        d[f*COORD_W +: COORD_W] = COORD_W'($urandom());
    end
    return d;
  endfunction

  // Pair built to cross near t = k1/kd, u = k2/kd, sometimes nudged off.
  task automatic put_near_hit();
    int lim, kd, k1, k2, ax, ay, adx, ady, bdx, bdy, bx, by;
    lim = 1 << $urandom_range(1, COORD_W - 3);
    kd  = $urandom_range(1, 255);
    k1  = $urandom_range(0, kd);
    k2  = $urandom_range(0, kd);
    ax  = span(lim);
    ay  = span(lim);
    adx = span(lim);
    ady = span(lim);
    bdx = span(lim);
    bdy = span(lim);
    bx  = ax + (adx * k1) / kd - (bdx * k2) / kd;
    by  = ay + (ady * k1) / kd - (bdy * k2) / kd;
    if ($urandom_range(0, 3) == 0) begin
      bx += $urandom_range(0, 6) - 3;
      by += $urandom_range(0, 6) - 3;
    end
    put_coords(ax, ay, adx, ady, bx, by, bdx, bdy);
  endtask

  // Parallel, collinear or degenerate pairs.
  task automatic put_parallel();
    int lim, m, j, ax, ay, adx, ady, bx, by;
    lim = 1 << $urandom_range(1, COORD_W - 5);
    m   = $urandom_range(0, 6) - 3;
    ax  = span(lim);
    ay  = span(lim);
    adx = span(lim);
    ady = span(lim);
    if ($urandom_range(0, 1) == 0) begin
      j  = $urandom_range(0, 4) - 2;
      bx = ax + adx * j;
      by = ay + ady * j;
    end else begin
      bx = span(lim);
      by = span(lim);
    end
    put_coords(ax, ay, adx, ady, bx, by, adx * m, ady * m);
  endtask

  initial begin
    int pick;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: degenerate, boundary touches on both denominator signs, extremes.
    put_coords(0, 0, 0, 0, 0, 0, 0, 0);
    put_coords(0, 0, 100, 0, 50, -50, 0, 100);
    put_coords(5, 7, 10, 10, -3, 2, 20, 20);
    put_coords(1, 1, 0, 0, -5, -5, 10, 10);
    put_coords(0, 0, 10, 0, 0, -5, 0, 10);
    put_coords(0, 0, 10, 0, 10, -5, 0, 10);
    put_coords(0, 0, 10, 0, 10, 5, 0, -10);
    put_coords(0, 0, 10, 0, 0, 5, 0, -10);
    put_coords(0, 0, 10, 0, 5, 0, 0, 10);
    put_coords(0, 0, 10, 0, 5, -10, 0, 10);
    put_coords(0, 0, 10, 0, 11, -5, 0, 10);
    put_coords(0, 0, 10, 0, -1, -5, 0, 10);
    put_coords(0, 0, 10, 0, 5, 1, 0, 10);
    put_coords(0, 0, 3, 0, 1, -1, 0, 2);
    put_coords(CMIN, 0, CMAX, 0, 0, CMIN, 0, CMAX);
    put_coords(CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN);
    put_coords(CMAX, CMAX, CMIN, CMIN, CMIN, CMIN, CMAX, CMAX);
    put_coords(CMAX, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMIN);
    put_coords(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN);
    put_coords(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX);
    put_beat({(S_TDATA_W / 2){2'b01}});
    put_beat({(S_TDATA_W / 2){2'b10}});
    wait_drained();

    // Random: mostly near-crossing pairs, mixed with parallel and raw fields.
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n == 300)
        calm <= 1'b1;
      else if (n == 450)
        calm <= 1'b0;
      if (n == 700)
        wait_drained();
      pick = $urandom_range(0, 99);
      if (pick < 55)
        put_near_hit();
      else if (pick < 70)
        put_parallel();
      else
        put_beat(raw_pair());
    end
    s_tvalid <= 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
